### rtl/fixed_latency_line_memory_assert.svh
// Assertion macros for the fixed-latency line memory checker.
// Needs nothing else; include it by bare file name.
`ifndef FIXED_LATENCY_LINE_MEMORY_ASSERT_SVH
`define FIXED_LATENCY_LINE_MEMORY_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define FLLM_ASSERT_HOLD(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fllm: condition violated");

// Check that a condition implies another at the same edge.
`define FLLM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fllm: implication violated");

// Check that a condition implies another a fixed number of edges later.
`define FLLM_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("fllm: delayed implication violated");

`endif

### rtl/fllm_pkg.sv
// Shared types and constants for the fixed-latency line memory.
// No dependencies; used by the top level and its checker.
package fllm_pkg;

    localparam int WORD_W    = 32;
    localparam int ID_W      = 8;
    localparam int LAT_W     = 8;
    localparam int MAX_WORDS = 4;

    // Cycles from the accepting edge to the edge that registers the result.
    localparam int PIPE_LATENCY = 6;

    localparam logic [LAT_W-1:0] LAT_RESET = 8'd4;

    typedef logic [WORD_W-1:0] t_word;

endpackage

### rtl/fixed_latency_line_memory.sv
// Fixed-latency, polled line memory: a pipeline that takes one word per cycle while busy is low.
// Result: a strobe o_valid appears for one cycle per accepted word, registered at the end of the pipeline.
// Throughput: one word per cycle while busy is low; the address wrap goes through a pipelined reciprocal unit.
// Reset: synchronous, active low; after reset busy stays high while the clearing pass
// zeroes the line memory one line per cycle.
// The receiver cannot stall; config writes are taken at any time, also during the clear.
module fixed_latency_line_memory #(
    parameter int NUM_LINES  = 64,
    parameter int LINE_WORDS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_op,
    input  logic signed [31:0]        i_word_address,
    input  logic [fllm_pkg::ID_W-1:0] i_requester_id,
    input  fllm_pkg::t_word           i_store_word0,
    input  fllm_pkg::t_word           i_store_word1,
    input  fllm_pkg::t_word           i_store_word2,
    input  fllm_pkg::t_word           i_store_word3,
    input  logic                      i_cfg_we,
    input  logic [fllm_pkg::LAT_W-1:0] i_cfg_wdata,
    output logic                      o_valid,
    output logic                      o_still_pending,
    output fllm_pkg::t_word           o_load_word0,
    output fllm_pkg::t_word           o_load_word1,
    output fllm_pkg::t_word           o_load_word2,
    output fllm_pkg::t_word           o_load_word3
);
    import fllm_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes and constants for the address wrap
    // ------------------------------------------------------------------
    localparam int TW  = NUM_LINES * LINE_WORDS;
    localparam int AW  = (TW > 1) ? $clog2(TW) : 1;
    localparam int LNW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    // Smallest multiple of TW that lifts any signed 32-bit address to >= 0.
    localparam longint KOFS_L = (((longint'(1) << 31) + TW - 1) / TW) * TW;
    localparam logic [32:0] KOFS = 33'(KOFS_L);
    // 2^16 mod TW, used to fold the upper half into the lower half.
    localparam logic [14:0] FOLD_C = 15'((1 << 16) % TW);
    // floor(2^32 / TW): quotient estimate is off by at most one.
    localparam logic [32:0] RECIP = 33'((longint'(1) << 32) / TW);
    // Reciprocal of LINE_WORDS for the line index, exact for values below 2^AW.
    localparam int SL  = AW + 2;
    localparam int SLW = SL + 1;
    localparam logic [SL:0] LRECIP =
        SLW'(((longint'(1) << SL) + LINE_WORDS - 1) / LINE_WORDS);
    localparam int LPW = AW + SLW;

    typedef enum logic [1:0] {
        KIND_IDLE  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_STORE = 2'd2
    } t_kind;

    // Per-word payload that rides along with the address through the pipe.
    typedef struct packed {
        logic                             op;
        logic [ID_W-1:0]                  req;
        logic [LINE_WORDS-1:0][WORD_W-1:0] data;
    } t_carry;

    localparam int NSTG = PIPE_LATENCY;

    // ------------------------------------------------------------------
    // Accept and configuration
    // ------------------------------------------------------------------
    logic       accept;
    logic       r_clearing;
    logic [LNW-1:0] r_clr_line;
    logic [LAT_W-1:0] r_latency;

    assign busy   = r_clearing;
    assign accept = start && !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latency <= LAT_RESET;
        end else if (i_cfg_we) begin
            r_latency <= i_cfg_wdata;
        end
    end

    // Clearing pass: walk every line once after reset, hold off new words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_line <= '0;
        end else if (r_clearing) begin
            if (r_clr_line == LNW'(NUM_LINES - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_line <= r_clr_line + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Input register and payload pipeline
    // ------------------------------------------------------------------
    t_word  in_words [MAX_WORDS];
    t_carry n_carry;
    t_carry r_car [NSTG];
    logic [NSTG-1:0] r_vld;
    logic [31:0] r_addr0;

    assign in_words[0] = i_store_word0;
    assign in_words[1] = i_store_word1;
    assign in_words[2] = i_store_word2;
    assign in_words[3] = i_store_word3;

    always_comb begin
        n_carry.op  = i_op;
        n_carry.req = i_requester_id;
        for (int k = 0; k < LINE_WORDS; k++) begin
            n_carry.data[k] = in_words[k];
        end
    end

    // Valid bits advance every cycle; the receiver never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_car[0] <= n_carry;
        r_addr0  <= i_word_address;
        for (int s = 1; s < NSTG; s++) begin
            r_car[s] <= r_car[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Address wrap: signed address mod TW, then line index
    // ------------------------------------------------------------------
    // Stage 1: lift to non-negative, fold the upper 17 bits down.
    logic [32:0] lifted;
    logic [31:0] fold_prod;
    logic [31:0] r_v1;

    assign lifted    = {r_addr0[31], r_addr0} + KOFS;
    assign fold_prod = 32'(lifted[32:16]) * 32'(FOLD_C);

    always_ff @(posedge i_clk) begin
        r_v1 <= fold_prod + 32'(lifted[15:0]);
    end

    // Stage 2: quotient estimate by reciprocal multiply.
    logic [64:0] q_prod;
    logic [31:0] r_q2;
    logic [31:0] r_v2;

    assign q_prod = 65'(r_v1) * 65'(RECIP);

    always_ff @(posedge i_clk) begin
        r_q2 <= q_prod[63:32];
        r_v2 <= r_v1;
    end

    // Stage 3: back-multiply the quotient.
    logic [31:0] r_qt3;
    logic [31:0] r_v3;

    always_ff @(posedge i_clk) begin
        r_qt3 <= r_q2 * 32'(TW);
        r_v3  <= r_v2;
    end

    // Stage 4: remainder is below 2*TW; one compare and subtract fixes it.
    logic [31:0] diff;
    logic [AW:0] rem;
    logic [AW-1:0] r_addr4;

    assign diff = r_v3 - r_qt3;
    assign rem  = diff[AW:0];

    always_ff @(posedge i_clk) begin
        if (rem >= (AW+1)'(TW)) begin
            r_addr4 <= AW'(rem - (AW+1)'(TW));
        end else begin
            r_addr4 <= AW'(rem);
        end
    end

    // Stage 5: line index = wrapped address / LINE_WORDS.
    logic [LPW-1:0] l_prod;
    logic [AW-1:0]  r_addr5;
    logic [LNW-1:0] r_line5;

    assign l_prod = LPW'(r_addr4) * LPW'(LRECIP);

    always_ff @(posedge i_clk) begin
        r_addr5 <= r_addr4;
        r_line5 <= LNW'(l_prod >> SL);
    end

    // ------------------------------------------------------------------
    // Request tracker: latch, count down, complete
    // ------------------------------------------------------------------
    t_kind            r_act_kind, n_act_kind;
    logic [ID_W-1:0]  r_act_req,  n_act_req;
    logic [AW-1:0]    r_act_addr, n_act_addr;
    logic [LAT_W-1:0] r_cnt,      n_cnt;
    logic [LINE_WORDS-1:0][WORD_W-1:0] r_pend;

    t_kind  cur_kind;
    t_carry cur;
    logic   match;
    logic   do_write;
    logic   do_load;
    logic   do_capture;
    logic   n_pending;

    assign cur      = r_car[NSTG-1];
    assign cur_kind = cur.op ? KIND_STORE : KIND_LOAD;
    assign match    = (r_act_kind == cur_kind) && (r_act_req == cur.req)
                   && (r_act_addr == r_addr5);

    always_comb begin
        n_act_kind = r_act_kind;
        n_act_req  = r_act_req;
        n_act_addr = r_act_addr;
        n_cnt      = r_cnt;
        do_write   = 1'b0;
        do_load    = 1'b0;
        do_capture = 1'b0;
        n_pending  = 1'b1;
        if (r_vld[NSTG-1]) begin
            if (r_act_kind == KIND_IDLE) begin
                // Idle: latch the request and arm the countdown.
                n_act_kind = cur_kind;
                n_act_req  = cur.req;
                n_act_addr = r_addr5;
                n_cnt      = r_latency;
                do_capture = cur.op;
            end else if (match) begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    // Countdown spent: finish and drop back to idle.
                    n_pending  = 1'b0;
                    do_load    = (cur_kind == KIND_LOAD);
                    do_write   = (cur_kind == KIND_STORE);
                    n_act_kind = KIND_IDLE;
                    n_act_req  = '0;
                    n_act_addr = '0;
                    n_cnt      = '0;
                end
            end
            // Mismatched words see busy and change nothing.
        end
    end

    logic r_out_vld;
    logic r_out_pend;
    logic r_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_kind <= KIND_IDLE;
            r_act_req  <= '0;
            r_act_addr <= '0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
            r_out_pend <= 1'b1;
            r_out_load <= 1'b0;
        end else begin
            r_act_kind <= n_act_kind;
            r_act_req  <= n_act_req;
            r_act_addr <= n_act_addr;
            r_cnt      <= n_cnt;
            r_out_vld  <= r_vld[NSTG-1];
            r_out_pend <= n_pending;
            r_out_load <= do_load;
        end
    end

    // Store line is only read by the store that captured it.
    always_ff @(posedge i_clk) begin
        if (do_capture) begin
            r_pend <= cur.data;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one write port (clear or store), one registered read
    // ------------------------------------------------------------------
    logic [LINE_WORDS-1:0][WORD_W-1:0] mem [NUM_LINES];
    logic [LINE_WORDS-1:0][WORD_W-1:0] r_rd_line;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_line] <= '0;
        end else if (do_write) begin
            mem[r_line5] <= r_pend;
        end
        r_rd_line <= mem[r_line5];
    end

    // ------------------------------------------------------------------
    // Result ports: load words read 0 unless a load just completed
    // ------------------------------------------------------------------
    t_word out_words [MAX_WORDS];

    always_comb begin
        for (int k = 0; k < MAX_WORDS; k++) begin
            out_words[k] = '0;
        end
        for (int k = 0; k < LINE_WORDS; k++) begin
            out_words[k] = r_out_load ? r_rd_line[k] : '0;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_still_pending = r_out_pend;
    assign o_load_word0    = out_words[0];
    assign o_load_word1    = out_words[1];
    assign o_load_word2    = out_words[2];
    assign o_load_word3    = out_words[3];

endmodule

### rtl/fllm_checker.sv
// Port-level checker for the fixed-latency line memory, bound to the top level.
// Depends on fllm_pkg and fixed_latency_line_memory_assert.svh.
`include "fixed_latency_line_memory_assert.svh"

module fllm_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_valid,
    input logic            o_still_pending,
    input fllm_pkg::t_word o_load_word0,
    input fllm_pkg::t_word o_load_word1,
    input fllm_pkg::t_word o_load_word2,
    input fllm_pkg::t_word o_load_word3
);
    import fllm_pkg::*;

    logic acc;
    logic words_zero;

    assign acc        = start && !busy;
    assign words_zero = (o_load_word0 == '0) && (o_load_word1 == '0)
                     && (o_load_word2 == '0) && (o_load_word3 == '0);

    `FLLM_ASSERT_DELAY(a_acc_gives_strobe, i_clk, i_rst_n, acc, PIPE_LATENCY + 1, o_valid)
    `FLLM_ASSERT_DELAY(a_no_acc_no_strobe, i_clk, i_rst_n, !acc, PIPE_LATENCY + 1, !o_valid)
    `FLLM_ASSERT_IMPL(a_pending_words_zero, i_clk, i_rst_n, o_still_pending, words_zero)
    `FLLM_ASSERT_HOLD(a_no_strobe_in_clear, i_clk, i_rst_n, !(busy && o_valid))

endmodule

bind fixed_latency_line_memory fllm_checker u_fllm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_still_pending (o_still_pending),
    .o_load_word0    (o_load_word0),
    .o_load_word1    (o_load_word1),
    .o_load_word2    (o_load_word2),
    .o_load_word3    (o_load_word3)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fixed_latency_line_memory: polled line loads and stores,
// checked against an in-bench model of the line store. Needs fllm_pkg and the RTL.
module tb;
    import fllm_pkg::*;

    localparam int NUM_LINES    = 64;
    localparam int LINE_WORDS   = 4;
    localparam int TOTAL_WORDS  = NUM_LINES * LINE_WORDS;
    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = PIPE_LATENCY + 4;
    localparam int PHASES       = 8;
    localparam int LONG_BUDGET  = 250;
    localparam int SHORT_BUDGET = 135;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef enum logic [1:0] {KIND_IDLE, KIND_LOAD, KIND_STORE} t_kind;

    typedef t_word [MAX_WORDS-1:0] t_line;

    // One call into the memory, as it goes out on the request ports.
    typedef struct packed {
        logic               op;
        logic signed [31:0] addr;
        logic [ID_W-1:0]    id;
        t_line              data;
    } t_call;

    // What the memory answers to one call.
    typedef struct packed {
        logic  pending;
        t_line data;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_op;
    logic signed [31:0] i_word_address;
    logic [ID_W-1:0]    i_requester_id;
    t_word              i_store_word0;
    t_word              i_store_word1;
    t_word              i_store_word2;
    t_word              i_store_word3;
    logic               i_cfg_we;
    logic [LAT_W-1:0]   i_cfg_wdata;
    logic               o_valid;
    logic               o_still_pending;
    t_word              o_load_word0;
    t_word              o_load_word1;
    t_word              o_load_word2;
    t_word              o_load_word3;

    fixed_latency_line_memory #(
        .NUM_LINES  (NUM_LINES),
        .LINE_WORDS (LINE_WORDS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_word_address  (i_word_address),
        .i_requester_id  (i_requester_id),
        .i_store_word0   (i_store_word0),
        .i_store_word1   (i_store_word1),
        .i_store_word2   (i_store_word2),
        .i_store_word3   (i_store_word3),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_still_pending (o_still_pending),
        .o_load_word0    (o_load_word0),
        .o_load_word1    (o_load_word1),
        .o_load_word2    (o_load_word2),
        .o_load_word3    (o_load_word3)
    );

    // ------------------------------------------------------------------
    // Model of the memory: line store, the one active request, countdown
    // and the latency register. Updated at every accepted word.
    // ------------------------------------------------------------------
    t_word            line_mem [TOTAL_WORDS];
    t_kind            act_kind;
    logic [ID_W-1:0]  act_id;
    int               act_addr;
    logic [LAT_W-1:0] countdown;
    t_line            held_line;
    logic [LAT_W-1:0] latency;

    // Predicted answers, oldest first, waiting for their result strobe.
    t_answer poll_answers [$];

    int          fail_count;
    int          calls_sent;
    int          loads_done;
    int          stores_done;
    int          settings_used;
    int          burst_left;
    bit          gaps_on;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Wrap a signed word address into 0 .. TOTAL_WORDS-1, negatives to the top.
    function automatic int wrap_word_addr(logic signed [31:0] raw);
        longint r;
        r = longint'(raw) % TOTAL_WORDS;
        if (r < 0) begin
            r += TOTAL_WORDS;
        end
        return r[31:0];
    endfunction

    // Advance the model by one call and return what the memory must answer.
    function automatic t_answer answer_call(t_call c);
        t_answer ans;
        t_kind   kind;
        int      waddr;
        int      base;
        int      i;
        kind  = (c.op == OP_STORE) ? KIND_STORE : KIND_LOAD;
        waddr = wrap_word_addr(c.addr);
        base  = ((waddr / LINE_WORDS) % NUM_LINES) * LINE_WORDS;
        ans.pending = 1'b1;
        ans.data    = '0;
        if (act_kind == KIND_IDLE) begin
            // Latch the request; only a store captures its line.
            act_kind  = kind;
            act_id    = c.id;
            act_addr  = waddr;
            countdown = latency;
            held_line = '0;
            if (kind == KIND_STORE) begin
                for (i = 0; i < LINE_WORDS; i++) held_line[i] = c.data[i];
            end
        end else if (act_id == c.id && act_kind == kind && act_addr == waddr) begin
            if (countdown != 0) begin
                countdown--;
            end else begin
                if (kind == KIND_LOAD) begin
                    for (i = 0; i < LINE_WORDS; i++) ans.data[i] = line_mem[base + i];
                    loads_done++;
                end else begin
                    for (i = 0; i < LINE_WORDS; i++) line_mem[base + i] = held_line[i];
                    stores_done++;
                end
                ans.pending = 1'b0;
                act_kind    = KIND_IDLE;
                act_id      = '0;
                act_addr    = 0;
                countdown   = '0;
            end
        end
        // Any other call sees the memory busy and changes nothing.
        return ans;
    endfunction

    // Pick a raw address that wraps to the given word: itself, or a far alias
    // on the positive or the negative side.
    function automatic logic signed [31:0] alias_addr(int waddr);
        longint span;
        longint k;
        longint a;
        span = 64'sd2147483648 / TOTAL_WORDS;
        k    = $urandom_range(0, span - 1);
        case ($urandom_range(0, 2))
            0: a = waddr;
            1: a = longint'(waddr) + k * TOTAL_WORDS;
            default: a = longint'(waddr) - (k + 1) * TOTAL_WORDS;
        endcase
        return a[31:0];
    endfunction

    // Mix full-range addresses with a hot low region, small negatives and the
    // corners, so loads often land on lines that were stored.
    function automatic logic signed [31:0] rand_addr();
        logic signed [31:0] a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: a = $urandom;
            4, 5, 6:    a = $urandom_range(0, 31);
            7, 8:       a = -$signed({1'b0, 31'($urandom_range(1, 32))});
            default: begin
                case ($urandom_range(0, 3))
                    0: a = 32'h7FFF_FFFF;
                    1: a = 32'h8000_0000;
                    2: a = 32'h0000_0000;
                    default: a = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return a;
    endfunction

    function automatic t_call make_call(logic op, logic signed [31:0] addr,
                                        logic [ID_W-1:0] id);
        t_call c;
        int    i;
        c.op   = op;
        c.addr = addr;
        c.id   = id;
        for (i = 0; i < MAX_WORDS; i++) c.data[i] = $urandom;
        return c;
    endfunction

    function automatic t_call random_call();
        return make_call(1'($urandom_range(0, 1)), rand_addr(), ID_W'($urandom_range(0, 255)));
    endfunction

    // Send one word. Gaps come between bursts of random length; start stays
    // high across a burst so back-to-back words go out every cycle while busy is low.
    task automatic send_call(input t_call c, output t_answer ans);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_op           <= c.op;
        i_word_address <= c.addr;
        i_requester_id <= c.id;
        i_store_word0  <= c.data[0];
        i_store_word1  <= c.data[1];
        i_store_word2  <= c.data[2];
        i_store_word3  <= c.data[3];
        burst_left--;
        // Hold the word until an edge finds busy low.
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ans = answer_call(c);
        poll_answers.push_back(ans);
        calls_sent++;
    endtask

    // Drop start and wait for every predicted answer to come back.
    task automatic wait_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (poll_answers.size() != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic set_latency(input logic [LAT_W-1:0] value);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        latency = value;
        settings_used++;
    endtask

    // A call that must not match the active request: another requester, the
    // other operation, another word of the address space, or anything at all.
    task automatic send_noise();
        t_call           c;
        t_answer         ans;
        logic            op_same;
        logic [ID_W-1:0] bump;
        if (act_kind == KIND_IDLE) return;
        op_same = (act_kind == KIND_STORE) ? OP_STORE : OP_LOAD;
        c = make_call(op_same, alias_addr(act_addr), act_id);
        case ($urandom_range(0, 3))
            0: begin
                bump = ID_W'($urandom_range(1, 255));
                c.id = act_id + bump;
            end
            1: c.op = ~op_same;
            2: c.addr = alias_addr((act_addr + $urandom_range(1, TOTAL_WORDS - 1)) % TOTAL_WORDS);
            default: c = random_call();
        endcase
        send_call(c, ans);
    endtask

    // Poll the active request, as its owner, until it completes.
    task automatic finish_active();
        t_call   c;
        t_answer ans;
        while (act_kind != KIND_IDLE) begin
            c = make_call((act_kind == KIND_STORE) ? OP_STORE : OP_LOAD,
                          alias_addr(act_addr), act_id);
            send_call(c, ans);
        end
    endtask

    // Issue a request and keep polling it to completion, with other callers
    // cutting in now and then.
    task automatic run_request(input logic op, input logic signed [31:0] addr,
                               input logic [ID_W-1:0] id, input t_line data,
                               input int noise_pct);
        t_call   c;
        t_answer ans;
        c      = make_call(op, addr, id);
        c.data = data;
        send_call(c, ans);
        while (ans.pending) begin
            if (act_kind != KIND_IDLE && $urandom_range(0, 99) < noise_pct) begin
                send_noise();
            end else begin
                c = make_call(op, ($urandom_range(0, 3) == 0) ?
                              alias_addr(wrap_word_addr(addr)) : addr, id);
                send_call(c, ans);
            end
        end
    endtask

    // Start a request, poll it part way, let others cut in, then resume.
    task automatic broken_request();
        t_call   c;
        t_answer ans;
        int      n;
        int      i;
        c = random_call();
        send_call(c, ans);
        n = $urandom_range(0, 3);
        while (n > 0 && act_kind != KIND_IDLE && countdown != 0) begin
            c = make_call((act_kind == KIND_STORE) ? OP_STORE : OP_LOAD,
                          alias_addr(act_addr), act_id);
            send_call(c, ans);
            n--;
        end
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) send_noise();
        finish_active();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset latency and the cleared store: the last line must read back zero.
    task automatic test_reset_state();
        gaps_on = 1'b0;
        run_request(OP_LOAD, TOTAL_WORDS - LINE_WORDS, 8'd17, '0, 0);
    endtask

    // Corner addresses, requester ids and data patterns at zero latency.
    task automatic test_field_extremes();
        set_latency(8'd0);
        run_request(OP_STORE, 32'hFFFF_FFFF, 8'd255, '1, 0);
        run_request(OP_LOAD, 32'h7FFF_FFFF, 8'd0, '0, 0);
        run_request(OP_STORE, 32'h8000_0000, 8'd0,
                    {32'hA5A5_5A5A, 32'h0000_0001, 32'h8000_0000, 32'h5A5A_A5A5}, 0);
        run_request(OP_LOAD, 32'h0000_0000, 8'd255, '0, 0);
    endtask

    // Each way a call can miss the active request, then far aliases on both sides
    // that do match, then a load from another word of the same line.
    task automatic test_mismatched_calls();
        t_call   c;
        t_answer ans;
        t_line   pattern;
        pattern = {32'h0000_FFFF, 32'hFFFF_0000, 32'h89AB_CDEF, 32'h0123_4567};
        set_latency(8'd1);
        gaps_on = 1'b1;
        c = make_call(OP_STORE, 32'sd8, 8'd3);
        c.data = pattern;
        send_call(c, ans);
        send_call(make_call(OP_STORE, 32'sd8, 8'd4), ans);
        send_call(make_call(OP_LOAD, 32'sd8, 8'd3), ans);
        send_call(make_call(OP_STORE, 32'sd9, 8'd3), ans);
        send_call(make_call(OP_STORE, 32'sd8 + TOTAL_WORDS, 8'd3), ans);
        send_call(make_call(OP_STORE, 32'sd8 - TOTAL_WORDS, 8'd3), ans);
        run_request(OP_LOAD, 32'sd10, 8'd200, '0, 0);
    endtask

    // Random traffic over several latency settings, the extremes among them.
    task automatic test_random_traffic();
        int               phase;
        int               phase_start;
        int               budget;
        logic [LAT_W-1:0] lat;
        int               pick;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: lat = 8'd0;
                1: lat = 8'd255;
                2: lat = 8'd1;
                3: lat = LAT_RESET;
                default: lat = LAT_W'($urandom_range(0, 12));
            endcase
            set_latency(lat);
            budget      = (lat == 8'd255) ? LONG_BUDGET : SHORT_BUDGET;
            gaps_on     = (phase % 3) != 1;
            phase_start = calls_sent;
            while (calls_sent - phase_start < budget) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    run_request(1'($urandom_range(0, 1)), rand_addr(),
                                ID_W'($urandom_range(0, 255)),
                                {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)},
                                15);
                end else if (pick < 90) begin
                    broken_request();
                end else begin
                    send_noise();
                    broken_request();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Answer checker: every strobe pops the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_answer
        t_answer want;
        t_line   got;
        int      i;
        if (i_rst_n && o_valid === 1'b1) begin
            if (poll_answers.size() == 0) begin
                $error("answer word with nothing expected");
                fail_count++;
            end else begin
                want = poll_answers.pop_front();
                got  = {o_load_word3, o_load_word2, o_load_word1, o_load_word0};
                if (o_still_pending !== want.pending) begin
                    $error("still_pending: expected %0b, got %0b", want.pending, o_still_pending);
                    fail_count++;
                end
                for (i = 0; i < MAX_WORDS; i++) begin
                    if (got[i] !== want.data[i]) begin
                        $error("load_word%0d: expected %h, got %h", i, want.data[i], got[i]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : main
        int i;
        start          = 1'b0;
        i_op           = OP_LOAD;
        i_word_address = '0;
        i_requester_id = '0;
        i_store_word0  = '0;
        i_store_word1  = '0;
        i_store_word2  = '0;
        i_store_word3  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_rst_n        = 1'b0;
        fail_count     = 0;
        calls_sent     = 0;
        loads_done     = 0;
        stores_done    = 0;
        settings_used  = 0;
        burst_left     = 0;
        gaps_on        = 1'b0;
        cycle_count    = 0;
        // Model starts as the block leaves reset: cleared, idle, reset latency.
        for (i = 0; i < TOTAL_WORDS; i++) line_mem[i] = '0;
        act_kind  = KIND_IDLE;
        act_id    = '0;
        act_addr  = 0;
        countdown = '0;
        held_line = '0;
        latency   = LAT_RESET;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The clearing pass holds busy high; the first send waits it out.
        test_reset_state();
        test_field_extremes();
        test_mismatched_calls();
        test_random_traffic();

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d calls over %0d latency settings; %0d loads and %0d stores completed.",
                 calls_sent, settings_used, loads_done, stores_done);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
